@@ sv/c_comment_blanker_defines.svh @@
// assertion macros for the comment blanker, clocked on clk_i with rst_ni held off
`ifndef C_COMMENT_BLANKER_DEFINES_SVH
`define C_COMMENT_BLANKER_DEFINES_SVH

`ifndef SYNTHESIS
`define CCB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ccb assertion failed");
`define CCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ccb assertion failed");
`else
`define CCB_ASSERT_SAME(lbl, ante, cons)
`define CCB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/ccb_pkg.sv @@
`default_nettype none
package ccb_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH_HELD = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_STAR_HELD  = 3'd4
  } scan_mode_e;

  // one classified input transaction: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
    logic       err;
  } ccb_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ccb_queue_status_t;

endpackage
`default_nettype wire

@@ sv/ccb_front.sv @@
`default_nettype none
module ccb_front import ccb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [7:0]        byte_i,
  input  wire logic              last_i,
  input  wire ccb_queue_status_t q_status_i,
  output logic                   push_o,
  output ccb_entry_t             entry_o
);

  scan_mode_e mode_q, mode_d;
  logic [1:0] n;
  logic [7:0] b0, b1;
  logic       err;
  logic       accept;
  logic       is_nl;

  assign ready_o = !q_status_i.full;
  assign accept  = valid_i && ready_o;
  assign is_nl   = (byte_i == CH_NL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    mode_d = mode_q;
    n      = 2'd0;
    b0     = CH_SPACE;
    b1     = CH_SPACE;
    err    = 1'b0;
    unique case (mode_q)
      MODE_SLASH_HELD: begin
        n = 2'd2;
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_LINE;
        end else if (byte_i == CH_STAR) begin
          mode_d = MODE_BLOCK;
        end else begin
          // held slash was plain text
          b0     = CH_SLASH;
          b1     = byte_i;
          mode_d = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        n = 2'd1;
        if (is_nl) begin
          b0     = CH_NL;
          mode_d = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (byte_i == CH_STAR) begin
          mode_d = MODE_STAR_HELD;
        end else begin
          n  = 2'd1;
          b0 = is_nl ? CH_NL : CH_SPACE;
        end
      end
      MODE_STAR_HELD: begin
        if (byte_i == CH_SLASH) begin
          n      = 2'd2;
          mode_d = MODE_NORMAL;
        end else if (byte_i == CH_STAR) begin
          n = 2'd1;
        end else begin
          n      = 2'd2;
          b1     = is_nl ? CH_NL : CH_SPACE;
          mode_d = MODE_BLOCK;
        end
      end
      default: begin
        if (byte_i == CH_SLASH) begin
          mode_d = MODE_SLASH_HELD;
        end else begin
          n      = 2'd1;
          b0     = byte_i;
          mode_d = MODE_NORMAL;
        end
      end
    endcase

    if (last_i) begin
      err = (mode_d == MODE_BLOCK) || (mode_d == MODE_STAR_HELD);
      // flush whatever is still held
      if (mode_d == MODE_SLASH_HELD || mode_d == MODE_STAR_HELD) begin
        if (n == 2'd0) begin
          b0 = (mode_d == MODE_SLASH_HELD) ? CH_SLASH : CH_SPACE;
          n  = 2'd1;
        end else begin
          b1 = (mode_d == MODE_SLASH_HELD) ? CH_SLASH : CH_SPACE;
          n  = 2'd2;
        end
      end
      mode_d = MODE_NORMAL;
    end
  end

  assign push_o     = accept && (n != 2'd0);
  assign entry_o.two  = n[1];
  assign entry_o.b0   = b0;
  assign entry_o.b1   = b1;
  assign entry_o.last = last_i;
  assign entry_o.err  = err;

endmodule
`default_nettype wire

@@ sv/ccb_queue.sv @@
`default_nettype none
module ccb_queue import ccb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire ccb_entry_t  entry_i,
  input  wire logic        pop_i,
  output ccb_entry_t       head_o,
  output ccb_queue_status_t status_o
);

  ccb_entry_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/ccb_back.sv @@
`default_nettype none
module ccb_back import ccb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccb_entry_t        head_i,
  input  wire ccb_queue_status_t q_status_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [7:0]             byte_o,
  output logic                   last_o,
  output logic                   err_o
);

  logic       valid_q, valid_d;
  logic       sel_q, sel_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic       load;
  logic       fin;

  // output register may be refilled when empty or being taken
  assign load = !valid_q || ready_i;
  assign fin  = !head_i.two || sel_q;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_status_i.empty;
      if (!q_status_i.empty) begin
        byte_d = sel_q ? head_i.b1 : head_i.b0;
        last_d = fin && head_i.last;
        err_d  = fin && head_i.err;
        pop_o  = fin;
        sel_d  = !fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;
  assign err_o   = err_q;

endmodule
`default_nettype wire

@@ sv/c_comment_blanker.sv @@
// Streaming C/C++ comment blanker. Source text enters one byte per transaction with
// tlast on the final byte; the output is a copy of the same length in which comment
// markers and comment bodies are spaces and newlines inside comments are kept. A held
// slash or star costs no output until the following byte settles it, so one input
// byte gives zero, one or two output bytes. The front classifies a byte in the cycle
// it is accepted and takes one byte every cycle while the queue has room; a two-entry
// queue feeds the back, which drives one output byte per cycle from a registered
// output stage while the sink is ready. Throughput is set by the single-byte output
// port: bytes that start or end a marker, or that release a held character, give two
// output bytes. On the final output byte tuser flags a block comment left open; the
// whole stream should then be discarded. No clearing pass is needed after reset.
`default_nettype none
`include "c_comment_blanker_defines.svh"
module c_comment_blanker import ccb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o,   // out_last
  output logic            m_axis_tuser_o    // [0] unterminated_error
);

  ccb_entry_t        push_entry;
  ccb_entry_t        head_entry;
  ccb_queue_status_t q_status;
  logic              push;
  logic              pop;

  ccb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .byte_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  ccb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  ccb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_entry),
    .q_status_i (q_status),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .byte_o     (m_axis_tdata_o),
    .last_o     (m_axis_tlast_o),
    .err_o      (m_axis_tuser_o)
  );

  // error flag only rides on the final byte of a stream
  `CCB_ASSERT_SAME(a_err_only_on_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o)
  // an open block comment ends with blanked content only
  `CCB_ASSERT_SAME(a_err_byte_blank, m_axis_tvalid_o && m_axis_tuser_o,
                   m_axis_tdata_o == CH_SPACE || m_axis_tdata_o == CH_NL)
  `CCB_ASSERT_NEXT(a_push_fills_queue, push && !pop, !q_status.empty)

endmodule
`default_nettype wire
